@@ rtl/core/simon_pkg.sv @@
// Package: Simon 128/256 constants, types and round/key-schedule functions.
`timescale 1ns / 1ps

package simon_pkg;

    localparam int ROUNDS      = 72;
    localparam int KEY_WORDS   = 4;
    localparam int Z_PERIOD    = 62;
    localparam int WORD_W      = 64;
    localparam int STEP_W      = $clog2(ROUNDS + 1);
    localparam int ZIDX_W      = $clog2(Z_PERIOD);
    localparam int KIDX_W      = $clog2(KEY_WORDS);

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // z4 sequence, entry 0 is the leftmost bit
    localparam logic [0:Z_PERIOD-1] Z_SEQ =
        62'b11010001111001101011011000100000010111000011001010010011101111;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [ROUNDS-1:0] rk_array_t;

    function automatic word_t rotl(input word_t x, input int r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic word_t rotr(input word_t x, input int r);
        rotr = (x >> r) | (x << (WORD_W - r));
    endfunction

    function automatic word_t round_f(input word_t x);
        round_f = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

    // next round key from k[i-1], k[i-3], k[i-4] and the z bit
    function automatic word_t next_key(input word_t k1, input word_t k3,
                                       input word_t k4, input logic z);
        word_t t;
        t = rotr(k1, 3) ^ k3;
        t = t ^ rotr(t, 1);
        next_key = ~k4 ^ t ^ {{(WORD_W-1){1'b0}}, z} ^ word_t'(3);
    endfunction

endpackage

@@ rtl/core/simon_ks.sv @@
// Key registers and serial round-key expansion into a shift array.
`timescale 1ns / 1ps

module simon_ks
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [simon_pkg::KIDX_W-1:0]     cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]     cfg_data,
    output simon_pkg::rk_array_t             round_keys,
    output logic                             busy
);

    simon_pkg::word_t                   key_reg [simon_pkg::KEY_WORDS];
    simon_pkg::rk_array_t               rk_reg;
    logic [simon_pkg::STEP_W-1:0]       step_reg;
    logic [simon_pkg::ZIDX_W-1:0]       zidx_reg;
    simon_pkg::word_t                   key_next;

    assign busy       = (step_reg != simon_pkg::STEP_W'(simon_pkg::ROUNDS));
    assign round_keys = rk_reg;

    always_comb
    begin
        if (step_reg < simon_pkg::STEP_W'(simon_pkg::KEY_WORDS))
        begin
            key_next = key_reg[step_reg[simon_pkg::KIDX_W-1:0]];
        end
        else
        begin
            key_next = simon_pkg::next_key(rk_reg[simon_pkg::ROUNDS-1],
                                           rk_reg[simon_pkg::ROUNDS-3],
                                           rk_reg[simon_pkg::ROUNDS-4],
                                           simon_pkg::Z_SEQ[zidx_reg]);
        end
    end

    // control: restart expansion on any key write (and after reset)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            zidx_reg <= '0;
            for (int i = 0; i < simon_pkg::KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
            step_reg <= '0;
            zidx_reg <= '0;
        end
        else if (busy)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg >= simon_pkg::STEP_W'(simon_pkg::KEY_WORDS))
            begin
                if (zidx_reg == simon_pkg::ZIDX_W'(simon_pkg::Z_PERIOD - 1))
                begin
                    zidx_reg <= '0;
                end
                else
                begin
                    zidx_reg <= zidx_reg + 1'b1;
                end
            end
        end
    end

    // shift each new key in at the top; after a full pass entry i is key i
    always_ff @(posedge clk)
    begin
        if (busy && !cfg_we)
        begin
            for (int i = 0; i < simon_pkg::ROUNDS - 1; i++)
            begin
                rk_reg[i] <= rk_reg[i+1];
            end
            rk_reg[simon_pkg::ROUNDS-1] <= key_next;
        end
    end

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("key write did not restart expansion");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= simon_pkg::STEP_W'(simon_pkg::ROUNDS))
        else $error("expansion step overran");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !cfg_we |=> !busy && $stable(rk_reg))
        else $error("round keys moved while idle");

endmodule

@@ rtl/core/simon_128_256_block_cipher.sv @@
// Top level: Simon 128/256 ECB cipher, one round per pipeline stage.
`timescale 1ns / 1ps

// channel   direction  payload
// s_axis    in         tuser: operation; tdata: word_a_in, word_b_in (128 bits)
// m_axis    out        tdata: word_a_out, word_b_out (128 bits)
// cfg       in         key_word_0..3 by cfg_index, 64-bit cfg_data
//
// 72 register stages, one Simon round each. One block may enter every cycle
// while s_tready is high, so throughput is one block per cycle when not stalled.
// Decrypt stages use the round keys in reverse order.
// Reset (and any key write) runs a serial key expansion; s_tready
// stays low while it runs.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.

module simon_128_256_block_cipher
(
    input  logic                             clk,
    input  logic                             rst_n,
    // word_a_in[63:0], word_b_in[127:64]
    input  logic [127:0]                     s_tdata,
    // operation[0]
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // word_a_out[63:0], word_b_out[127:64]
    output logic [127:0]                     m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [simon_pkg::KIDX_W-1:0]     cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]     cfg_data
);

    localparam int N = simon_pkg::ROUNDS;

    simon_pkg::rk_array_t   round_keys;
    logic                   ks_busy;
    logic                   advance;
    logic [N-1:0]           valid_reg;
    logic [N-1:0]           op_reg;
    simon_pkg::word_t       a_reg [N];
    simon_pkg::word_t       b_reg [N];
    simon_pkg::word_t       a_next [N];
    simon_pkg::word_t       b_next [N];

    simon_ks u_ks
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .round_keys (round_keys),
        .busy       (ks_busy)
    );

    // advance whole pipe unless the last stage holds a beat nobody takes
    assign advance  = !valid_reg[N-1] || m_tready;
    assign s_tready = advance && !ks_busy;
    assign m_tvalid = valid_reg[N-1];
    assign m_tdata  = {b_reg[N-1], a_reg[N-1]};

    // one round per stage; stage 0 takes the input beat
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            simon_pkg::word_t a_in;
            simon_pkg::word_t b_in;
            logic             op_in;
            if (j == 0)
            begin
                op_in = s_tuser;
                a_in  = s_tdata[63:0];
                b_in  = s_tdata[127:64];
            end
            else
            begin
                op_in = op_reg[j-1];
                a_in  = a_reg[j-1];
                b_in  = b_reg[j-1];
            end
            if (op_in == simon_pkg::OP_ENCRYPT)
            begin
                a_next[j] = b_in;
                b_next[j] = a_in ^ simon_pkg::round_f(b_in) ^ round_keys[j];
            end
            else
            begin
                a_next[j] = b_in ^ simon_pkg::round_f(a_in) ^ round_keys[N-1-j];
                b_next[j] = a_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[N-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg <= {op_reg[N-2:0], s_tuser};
            for (int j = 0; j < N; j++)
            begin
                a_reg[j] <= a_next[j];
                b_reg[j] <= b_next[j];
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !ks_busy)
        else $error("block accepted during key expansion");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

endmodule

@@ dv/tb_simon_128_256_block_cipher.sv @@
// Testbench: Simon 128/256 ECB cipher checked against its own round and key-schedule model.
`timescale 1ns / 1ps

module tb_simon_128_256_block_cipher;

    typedef struct packed {
        simon_pkg::word_t a;
        simon_pkg::word_t b;
    } block_t;

    logic             clk;
    logic             rst_n;
    logic [127:0]     s_tdata;
    logic             s_tuser;
    logic             s_tvalid;
    logic             s_tready;
    logic [127:0]     m_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic             cfg_we;
    logic [simon_pkg::KIDX_W-1:0] cfg_index;
    simon_pkg::word_t cfg_data;

    simon_128_256_block_cipher dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: key registers and the expanded schedule
    simon_pkg::word_t key_reg [simon_pkg::KEY_WORDS];
    simon_pkg::word_t sched   [simon_pkg::ROUNDS];
    block_t           cipher_q [$];

    int fails;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #20ms;
        $display("simon_128_256_block_cipher verification failed");
        $finish;
    end

    function automatic simon_pkg::word_t rol(input simon_pkg::word_t x, input int r);
        return (x << r) | (x >> (simon_pkg::WORD_W - r));
    endfunction

    function automatic simon_pkg::word_t mix(input simon_pkg::word_t x);
        return (rol(x, 1) & rol(x, 8)) ^ rol(x, 2);
    endfunction

    // rebuild the 72 round keys from the four key words
    function automatic void rebuild_schedule();
        simon_pkg::word_t t;
        simon_pkg::word_t z;
        for (int i = 0; i < simon_pkg::KEY_WORDS; i++)
            sched[i] = key_reg[i];
        for (int i = simon_pkg::KEY_WORDS; i < simon_pkg::ROUNDS; i++)
        begin
            t = rol(sched[i-1], simon_pkg::WORD_W - 3) ^ sched[i-3];
            t = t ^ rol(t, simon_pkg::WORD_W - 1);
            z = simon_pkg::word_t'(
                simon_pkg::Z_SEQ[(i - simon_pkg::KEY_WORDS) % simon_pkg::Z_PERIOD]);
            sched[i] = ~sched[i-4] ^ t ^ z ^ simon_pkg::word_t'(3);
        end
    endfunction

    function automatic block_t cipher_result(input logic op, input simon_pkg::word_t a,
                                             input simon_pkg::word_t b);
        simon_pkg::word_t t;
        if (op == simon_pkg::OP_ENCRYPT)
        begin
            for (int i = 0; i < simon_pkg::ROUNDS; i++)
            begin
                t = b;
                b = a ^ mix(b) ^ sched[i];
                a = t;
            end
        end
        else
        begin
            for (int i = simon_pkg::ROUNDS - 1; i >= 0; i--)
            begin
                t = a;
                a = b ^ mix(a) ^ sched[i];
                b = t;
            end
        end
        return '{a: a, b: b};
    endfunction

    function automatic simon_pkg::word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // receiver: random stall, or a forced hold-off while hold_left runs down
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare every output beat with the oldest expected block
    initial
    begin
        block_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("unexpected output beat %h", m_tdata);
                    fails++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (m_tdata[63:0] !== want.a)
                    begin
                        $error("word_a_out expected %h actual %h", want.a, m_tdata[63:0]);
                        fails++;
                    end
                    if (m_tdata[127:64] !== want.b)
                    begin
                        $error("word_b_out expected %h actual %h", want.b, m_tdata[127:64]);
                        fails++;
                    end
                end
            end
        end
    end

    // offer one block; hold valid across back-to-back beats
    task automatic send_block(input logic op, input simon_pkg::word_t a,
                              input simon_pkg::word_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cipher_q.push_back(cipher_result(op, a, b));
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (cipher_q.size() != 0)
        begin
            $error("%0d results missing after drain", cipher_q.size());
            fails++;
        end
        repeat (simon_pkg::ROUNDS + 10) @(posedge clk);
    endtask

    // key write only while idle; the block re-expands afterward
    task automatic write_key(input int idx, input simon_pkg::word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx[simon_pkg::KIDX_W-1:0];
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_reg[idx] = value;
        rebuild_schedule();
        @(posedge clk);
    endtask

    task automatic send_edges();
        simon_pkg::word_t one_hot;
        send_block(simon_pkg::OP_ENCRYPT, '0, '0);
        send_block(simon_pkg::OP_DECRYPT, '0, '0);
        send_block(simon_pkg::OP_ENCRYPT, '1, '1);
        send_block(simon_pkg::OP_DECRYPT, '1, '1);
        send_block(simon_pkg::OP_ENCRYPT, '1, '0);
        send_block(simon_pkg::OP_DECRYPT, '0, '1);
        one_hot = simon_pkg::word_t'(1) << $urandom_range(63);
        send_block(simon_pkg::OP_ENCRYPT, one_hot, ~one_hot);
        send_block(simon_pkg::OP_DECRYPT, ~one_hot, one_hot);
    endtask

    // reset key: schedule from the all-zero key
    task automatic test_zero_key();
        send_edges();
        drain();
    endtask

    // all-ones key, then a mixed key made by clearing words 0 and 2
    task automatic test_key_extremes();
        for (int k = 0; k < simon_pkg::KEY_WORDS; k++)
            write_key(k, '1);
        send_edges();
        drain();
        write_key(0, '0);
        write_key(2, '0);
        send_edges();
        drain();
    endtask

    // random keys and blocks under each idling profile; some round trips
    task automatic test_random_phases();
        int               send_pct [4] = '{0, 66, 0, 32};
        int               recv_pct [4] = '{0, 0, 66, 32};
        block_t           ct;
        simon_pkg::word_t a;
        simon_pkg::word_t b;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int k = 0; k < simon_pkg::KEY_WORDS; k++)
                write_key(k, rand_word());
            for (int n = 0; n < 220; n++)
            begin
                a = rand_word();
                b = rand_word();
                if (n % 4 == 0)
                begin
                    // encrypt then decrypt the ciphertext: must return the block
                    ct = cipher_result(simon_pkg::OP_ENCRYPT, a, b);
                    send_block(simon_pkg::OP_ENCRYPT, a, b);
                    send_block(simon_pkg::OP_DECRYPT, ct.a, ct.b);
                end
                else
                    send_block(logic'($urandom_range(1)), a, b);
            end
            drain();
        end
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        write_key(1, rand_word());
        write_key(3, rand_word());
        hold_left = 400;
        for (int n = 0; n < 150; n++)
            send_block(logic'($urandom_range(1)), rand_word(), rand_word());
        // pause until everything has come out, then resume
        drain();
        for (int n = 0; n < 40; n++)
            send_block(logic'($urandom_range(1)), rand_word(), rand_word());
        drain();
    endtask

    initial
    begin
        fails          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int k = 0; k < simon_pkg::KEY_WORDS; k++)
            key_reg[k] = '0;
        rebuild_schedule();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key();
        test_key_extremes();
        test_random_phases();
        test_backpressure();

        if (fails == 0)
            $display("simon_128_256_block_cipher verification clean");
        else
            $display("simon_128_256_block_cipher verification failed");
        $finish;
    end

endmodule

@@ simon_128_256_block_cipher.f @@
rtl/core/simon_pkg.sv
rtl/core/simon_ks.sv
rtl/core/simon_128_256_block_cipher.sv
dv/tb_simon_128_256_block_cipher.sv
